// ===== src/assert_macros.svh =====
// Assertion helpers shared by the deframer modules.
// Both expect the clock clk_i and the active-low reset rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`define SFD_ASSERT_NEVER(label, expr, msg) \
  `SFD_ASSERT(label, !(expr), msg)

`endif

// ===== src/sfd_pkg.sv =====
package sfd_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 5;
  localparam int OUT_BYTES   = 16;
  localparam int ROW_W       = 64;
  localparam int KEY_W       = 48;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = 2;

  localparam int MAX_PAYLOAD_DEF = 16;

  localparam logic [REG_IDX_W-1:0] REG_HEADER     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LEN    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_REPORT_LEN = 2'd2;

  localparam logic [BYTE_W-1:0] HEADER_RST     = 8'hAA;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST    = 5'd16;
  localparam logic [LEN_W-1:0]  REPORT_LEN_RST = 5'd9;

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_DATA,
    PH_CHECK
  } phase_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_WAKEUP = 2'd1,
    ACT_REPORT = 2'd2
  } action_e;

  typedef struct packed {
    logic             status;
    action_e          action;
    logic [LEN_W-1:0] length;
  } result_t;

endpackage

// ===== src/sfd_pay_mem.sv =====
module sfd_pay_mem #(
  parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  wr_en_i,
  input  logic [$clog2(((MAX_PAYLOAD+7)/8)*8)-1:0] wr_pos_i,
  input  logic [sfd_pkg::BYTE_W-1:0]            wr_data_i,
  input  logic                                  rd_en_i,
  output logic [sfd_pkg::ROW_W-1:0]             rd_low_o,
  output logic [sfd_pkg::ROW_W-1:0]             rd_high_o
);

  localparam int MEM_ROWS = (MAX_PAYLOAD + 7) / 8;
  localparam int RW       = (MEM_ROWS > 1) ? $clog2(MEM_ROWS) : 1;
  localparam int ROW1     = (MEM_ROWS > 1) ? 1 : 0;

  logic [sfd_pkg::ROW_W-1:0] mem [MEM_ROWS];
  logic [RW-1:0]             wr_row;
  logic [2:0]                wr_lane;
  logic [sfd_pkg::ROW_W-1:0] rd_low_q;
  logic [sfd_pkg::ROW_W-1:0] rd_high_q;

  assign wr_row  = RW'(wr_pos_i >> 3);
  assign wr_lane = wr_pos_i[2:0];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row][{wr_lane, 3'b000} +: sfd_pkg::BYTE_W] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_low_q  <= mem[RW'(0)];
      rd_high_q <= mem[RW'(ROW1)];
    end
  end

  assign rd_low_o  = rd_low_q;
  assign rd_high_o = rd_high_q;

endmodule

// ===== src/sfd_parser.sv =====
`include "assert_macros.svh"

module sfd_parser #(
  parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [sfd_pkg::BYTE_W-1:0]               rx_byte_i,
  input  logic                                     host_suspended_i,
  input  logic                                     host_ready_i,
  input  logic                                     slot_free_i,
  input  logic [sfd_pkg::BYTE_W-1:0]               header_byte_i,
  input  logic [sfd_pkg::LEN_W-1:0]                max_length_i,
  input  logic [sfd_pkg::LEN_W-1:0]                report_length_i,
  output logic                                     wr_en_o,
  output logic [$clog2(((MAX_PAYLOAD+7)/8)*8)-1:0] wr_pos_o,
  output logic [sfd_pkg::BYTE_W-1:0]               wr_data_o,
  output logic                                     rd_en_o,
  output sfd_pkg::result_t                         result_o
);

  localparam int PW = $clog2(((MAX_PAYLOAD + 7) / 8) * 8);

  sfd_pkg::phase_e                phase_q, phase_d;
  logic [sfd_pkg::BYTE_W-1:0]     sum_q, sum_d;
  logic [sfd_pkg::LEN_W-1:0]      len_q, len_d;
  logic [sfd_pkg::LEN_W-1:0]      bl_q, bl_d;
  logic [PW-1:0]                  wpos_q, wpos_d;
  logic                           accept;
  logic                           too_long;
  logic [sfd_pkg::BYTE_W-1:0]     sum_next;

  assign in_ready_o = (phase_q != sfd_pkg::PH_CHECK) || slot_free_i;
  assign accept     = in_valid_i && in_ready_o;
  assign sum_next   = sum_q + rx_byte_i;
  assign too_long   = (rx_byte_i > {3'b000, max_length_i}) ||
                      (rx_byte_i > sfd_pkg::BYTE_W'(MAX_PAYLOAD));

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      case (phase_q)
        sfd_pkg::PH_HUNT: begin
          if (rx_byte_i == header_byte_i) phase_d = sfd_pkg::PH_LEN;
        end
        sfd_pkg::PH_LEN: begin
          if (too_long) phase_d = sfd_pkg::PH_HUNT;
          else if (rx_byte_i == '0) phase_d = sfd_pkg::PH_CHECK;
          else phase_d = sfd_pkg::PH_DATA;
        end
        sfd_pkg::PH_DATA: begin
          if (bl_q == sfd_pkg::LEN_W'(1)) phase_d = sfd_pkg::PH_CHECK;
        end
        sfd_pkg::PH_CHECK: begin
          phase_d = sfd_pkg::PH_HUNT;
        end
        default: begin
          phase_d = sfd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    sum_d   = sum_q;
    len_d   = len_q;
    bl_d    = bl_q;
    wpos_d  = wpos_q;
    wr_en_o = 1'b0;
    rd_en_o = 1'b0;
    if (accept) begin
      case (phase_q)
        sfd_pkg::PH_HUNT: begin
          if (rx_byte_i == header_byte_i) sum_d = rx_byte_i;
        end
        sfd_pkg::PH_LEN: begin
          if (!too_long) begin
            sum_d  = sum_next;
            len_d  = rx_byte_i[sfd_pkg::LEN_W-1:0];
            bl_d   = rx_byte_i[sfd_pkg::LEN_W-1:0];
            wpos_d = '0;
          end
        end
        sfd_pkg::PH_DATA: begin
          sum_d   = sum_next;
          wr_en_o = 1'b1;
          wpos_d  = wpos_q + PW'(1);
          bl_d    = bl_q - sfd_pkg::LEN_W'(1);
        end
        sfd_pkg::PH_CHECK: begin
          rd_en_o = 1'b1;
          sum_d   = '0;
          bl_d    = '0;
        end
        default: begin
          sum_d = '0;
        end
      endcase
    end
  end

  always_comb begin
    result_o.status = (sum_next == '0) ? sfd_pkg::STATUS_GOOD : sfd_pkg::STATUS_BAD;
    result_o.action = sfd_pkg::ACT_NONE;
    result_o.length = len_q;
    if ((sum_next == '0) && (len_q == report_length_i)) begin
      if (host_suspended_i) result_o.action = sfd_pkg::ACT_WAKEUP;
      else if (host_ready_i) result_o.action = sfd_pkg::ACT_REPORT;
    end
  end

  assign wr_pos_o  = wpos_q;
  assign wr_data_o = rx_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfd_pkg::PH_HUNT;
      sum_q   <= '0;
      len_q   <= '0;
      bl_q    <= '0;
      wpos_q  <= '0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      len_q   <= len_d;
      bl_q    <= bl_d;
      wpos_q  <= wpos_d;
    end
  end

  `SFD_ASSERT(a_data_left, phase_q == sfd_pkg::PH_DATA |-> bl_q != '0, "payload phase with no words left")
  `SFD_ASSERT(a_wpos_in_frame, phase_q == sfd_pkg::PH_DATA |-> wpos_q < len_q, "write position beyond frame length")
  `SFD_ASSERT_NEVER(a_wr_rd_excl, wr_en_o && rd_en_o, "payload write and readout in one cycle")

endmodule

// ===== src/serial_frame_deframer_checksum.sv =====
// Serial frame deframer with additive checksum.
// The input channel (in_valid_i/in_ready_o) carries one received word per
// transfer, together with the host status flags sampled with that word.
// The block hunts for the header word, takes a length word, stores that many
// payload words in a small synchronous payload memory and checks the 8-bit
// sum of the whole frame on the checksum word.
// Only the checksum word gives a result on the output channel
// (out_valid_o/out_ready_i): status, action, frame length and the payload,
// with payload words at or beyond the frame length reported as zero.
// One word is accepted per cycle while in_ready_o is high; the result appears in the
// cycle after the checksum word is accepted, as the payload memory read is registered.
// If the receiver stalls, the result is held and only a following checksum
// word waits; header, length and payload words keep flowing meanwhile.
// Reset returns the block to header hunting and loads the default
// configuration; the payload memory needs no clearing pass.
// Configuration must be written over the APB port only while the block is idle; the block itself does not enforce it.
`include "assert_macros.svh"

module serial_frame_deframer_checksum #(
  parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [sfd_pkg::BYTE_W-1:0]          rx_byte_i,
  input  logic                                host_suspended_i,
  input  logic                                host_ready_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                status_o,
  output logic [1:0]                          action_o,
  output logic [sfd_pkg::LEN_W-1:0]           frame_length_o,
  output logic [sfd_pkg::BYTE_W-1:0]          modifier_keys_o,
  output logic [sfd_pkg::KEY_W-1:0]           key_codes_o,
  output logic [sfd_pkg::ROW_W-1:0]           payload_low_o,
  output logic [sfd_pkg::ROW_W-1:0]           payload_high_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sfd_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [sfd_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [sfd_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int PW = $clog2(((MAX_PAYLOAD + 7) / 8) * 8);

  logic [sfd_pkg::BYTE_W-1:0]  header_q;
  logic [sfd_pkg::LEN_W-1:0]   max_len_q;
  logic [sfd_pkg::LEN_W-1:0]   report_len_q;
  logic                        cfg_wr;
  logic [sfd_pkg::REG_IDX_W-1:0] cfg_idx;

  logic                        out_valid_q, out_valid_d;
  sfd_pkg::result_t            res_q;
  sfd_pkg::result_t            res_new;
  logic                        slot_free;

  logic                        wr_en;
  logic [PW-1:0]               wr_pos;
  logic [sfd_pkg::BYTE_W-1:0]  wr_data;
  logic                        rd_en;
  logic [sfd_pkg::ROW_W-1:0]   rd_low;
  logic [sfd_pkg::ROW_W-1:0]   rd_high;
  logic [2*sfd_pkg::ROW_W-1:0] rows;
  logic [2*sfd_pkg::ROW_W-1:0] masked;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[sfd_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q     <= sfd_pkg::HEADER_RST;
      max_len_q    <= sfd_pkg::MAX_LEN_RST;
      report_len_q <= sfd_pkg::REPORT_LEN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        sfd_pkg::REG_HEADER:     header_q     <= pwdata[sfd_pkg::BYTE_W-1:0];
        sfd_pkg::REG_MAX_LEN:    max_len_q    <= pwdata[sfd_pkg::LEN_W-1:0];
        sfd_pkg::REG_REPORT_LEN: report_len_q <= pwdata[sfd_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      sfd_pkg::REG_HEADER:     prdata = sfd_pkg::APB_DATA_W'(header_q);
      sfd_pkg::REG_MAX_LEN:    prdata = sfd_pkg::APB_DATA_W'(max_len_q);
      sfd_pkg::REG_REPORT_LEN: prdata = sfd_pkg::APB_DATA_W'(report_len_q);
      default:                 prdata = '0;
    endcase
  end

  assign slot_free = !out_valid_q || out_ready_i;

  sfd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .host_suspended_i (host_suspended_i),
    .host_ready_i     (host_ready_i),
    .slot_free_i      (slot_free),
    .header_byte_i    (header_q),
    .max_length_i     (max_len_q),
    .report_length_i  (report_len_q),
    .wr_en_o          (wr_en),
    .wr_pos_o         (wr_pos),
    .wr_data_o        (wr_data),
    .rd_en_o          (rd_en),
    .result_o         (res_new)
  );

  sfd_pay_mem #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_pay_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_pos_i  (wr_pos),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_low_o  (rd_low),
    .rd_high_o (rd_high)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (rd_en) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      res_q <= res_new;
    end
  end

  // Words at or beyond the frame length may be left over from older frames.
  assign rows = {rd_high, rd_low};

  always_comb begin
    masked = '0;
    for (int i = 0; i < sfd_pkg::OUT_BYTES; i++) begin
      if (sfd_pkg::LEN_W'(i) < res_q.length) begin
        masked[i*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W] = rows[i*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W];
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign action_o        = res_q.action;
  assign frame_length_o  = res_q.length;
  assign modifier_keys_o = masked[15:8];
  assign key_codes_o     = masked[71:24];
  assign payload_low_o   = masked[63:0];
  assign payload_high_o  = masked[127:64];

  `SFD_ASSERT(a_act_good, out_valid_q && res_q.action != sfd_pkg::ACT_NONE |-> res_q.status == sfd_pkg::STATUS_GOOD, "action on a bad frame")
  `SFD_ASSERT(a_short_high, out_valid_q && res_q.length <= 5'd8 |-> payload_high_o == '0, "upper payload set on a short frame")
  `SFD_ASSERT(a_rd_result, rd_en |=> out_valid_q, "checksum word gave no result")

endmodule
